@@ hw/rtl/bsd_pkg.sv @@
`default_nettype none

package bsd_pkg;

    localparam int NCH        = 3;
    localparam int PIX_W      = 8;
    localparam int HS_W       = 12;
    localparam int SUM_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THREE_CHANNELS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DITHER_ENABLE  = 2'd3;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_TAIL1,
        SEQ_TAIL2
    } seq_state_t;

    // Per-operation side information that travels down the pipeline.
    typedef struct packed {
        logic            emit;
        logic            clear_err;
        logic            line_end;
        logic            frame_end;
        logic            last;
        logic            use_hs;
        logic [4:0][1:0] slot;
    } op_meta_t;

    // Lane controls issued by the merge and pipeline logic.
    typedef struct packed {
        logic load_sum;
        logic load_out;
        logic clear_err;
        logic enable;
        logic dither;
    } lane_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/bsd_ram.sv @@
`default_nettype none

module bsd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read-first: a read and write at the same address return the old word.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/bsd_lane.sv @@
`default_nettype none

module bsd_lane (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire bsd_pkg::lane_ctrl_t         ctrl,
    input  wire logic [bsd_pkg::HS_W-1:0]    v0,
    input  wire logic [bsd_pkg::HS_W-1:0]    v1,
    input  wire logic [bsd_pkg::HS_W-1:0]    v2,
    input  wire logic [bsd_pkg::HS_W-1:0]    v3,
    input  wire logic [bsd_pkg::HS_W-1:0]    v4,
    output logic      [bsd_pkg::PIX_W-1:0]   res
);

    logic [bsd_pkg::SUM_W-1:0] sum_reg;
    logic [bsd_pkg::SUM_W-1:0] vsum;
    logic [bsd_pkg::SUM_W-1:0] dsum;
    logic [bsd_pkg::SUM_W-1:0] rsum;
    logic [bsd_pkg::PIX_W-1:0] err_reg;
    logic [bsd_pkg::PIX_W-1:0] res_reg;

    always_comb begin
        vsum = bsd_pkg::SUM_W'(v0) + bsd_pkg::SUM_W'(v4);
        vsum = vsum + ((bsd_pkg::SUM_W'(v1) + bsd_pkg::SUM_W'(v3)) << 2);
        vsum = vsum + (bsd_pkg::SUM_W'(v2) << 2) + (bsd_pkg::SUM_W'(v2) << 1);
        dsum = sum_reg + bsd_pkg::SUM_W'(err_reg);
        rsum = sum_reg + bsd_pkg::SUM_W'(128);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_sum) begin
            sum_reg <= vsum;
        end
        if (ctrl.load_out) begin
            if (!ctrl.enable) begin
                res_reg <= '0;
            end else if (ctrl.dither) begin
                res_reg <= dsum[bsd_pkg::SUM_W-1:bsd_pkg::PIX_W];
            end else begin
                res_reg <= rsum[bsd_pkg::SUM_W-1:bsd_pkg::PIX_W];
            end
        end
    end

    // The diffusion error runs across the whole frame in output order.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_reg <= '0;
        end else if (ctrl.clear_err) begin
            err_reg <= '0;
        end else if (ctrl.load_out && ctrl.enable && ctrl.dither) begin
            err_reg <= dsum[bsd_pkg::PIX_W-1:0];
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

@@ hw/rtl/binomial_smooth_5x5_dither.sv @@
`default_nettype none

// Separable 5x5 binomial smoother (taps 1,4,6,4,1) for raster-order pixels of one or three
// 8-bit channels, with edge pixels and edge rows replicated. Every transaction on the input
// channel is either a pixel or a flush step; outputs trail the input by two rows, so after
// the last pixel of a frame the user sends 2*image_width flush transactions to drive out
// the final two rows. Pixel transactions are taken while s_ready is high; the last pixel
// of a line yields up to three row sums and holds s_ready low while the TAIL1 and TAIL2
// states issue the rest, as the line stores have a single write port. Results pass
// through two pipeline stages (line store read, vertical sum) and then an output register
// that holds the rounded or dithered value. While a finished result waits for m_ready, up
// to two further result-producing operations still enter the pipeline before s_ready
// drops. The row sums of the last four lines live in four line store memories of MAX_WIDTH
// words each; they need no clearing after reset. Configuration is to be written through
// cfg_we/cfg_index/cfg_data only while the block is idle; the block does not enforce this.

module binomial_smooth_5x5_dither #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [bsd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bsd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_kind,
    input  wire logic [7:0]                        s_in_ch0,
    input  wire logic [7:0]                        s_in_ch1,
    input  wire logic [7:0]                        s_in_ch2,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [7:0]                             m_out_ch0,
    output logic [7:0]                             m_out_ch1,
    output logic [7:0]                             m_out_ch2,
    output logic                                   m_line_end,
    output logic                                   m_frame_end,
    output logic                                   m_last_of_run
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int LW = bsd_pkg::NCH * bsd_pkg::HS_W;

    // Configuration registers.
    logic [11:0] cfg_width_reg;
    logic [12:0] cfg_height_reg;
    logic        cfg_three_reg;
    logic        cfg_dither_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= 12'd640;
            cfg_height_reg <= 13'd480;
            cfg_three_reg  <= 1'b1;
            cfg_dither_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                bsd_pkg::CFG_IMAGE_WIDTH:    cfg_width_reg  <= cfg_data[11:0];
                bsd_pkg::CFG_IMAGE_HEIGHT:   cfg_height_reg <= cfg_data[12:0];
                bsd_pkg::CFG_THREE_CHANNELS: cfg_three_reg  <= cfg_data[0];
                bsd_pkg::CFG_DITHER_ENABLE:  cfg_dither_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // The programmed sizes are clamped to at least 2 by 4 and at most MAX_WIDTH by MAX_HEIGHT.
    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;

    always_comb begin
        if (cfg_width_reg < 12'd2) begin
            eff_w = WW'(2);
        end else if (32'(cfg_width_reg) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(cfg_width_reg);
        end
        if (cfg_height_reg < 13'd4) begin
            eff_h = HW'(4);
        end else if (32'(cfg_height_reg) > MAX_HEIGHT) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(cfg_height_reg);
        end
    end

    function automatic logic [bsd_pkg::HS_W-1:0] binom8(
        input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
        input logic [7:0] d, input logic [7:0] e);
        logic [bsd_pkg::HS_W-1:0] t;
        t = bsd_pkg::HS_W'(a) + bsd_pkg::HS_W'(e);
        t = t + ((bsd_pkg::HS_W'(b) + bsd_pkg::HS_W'(d)) << 2);
        t = t + (bsd_pkg::HS_W'(c) << 2) + (bsd_pkg::HS_W'(c) << 1);
        return t;
    endfunction

    // Sequencer state.
    bsd_pkg::seq_state_t state_reg, state_next;
    logic [XW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [XW-1:0] fl_x_reg, fl_x_next;
    logic          fl_half_reg, fl_half_next;
    logic          fl_pend_reg, fl_pend_next;
    logic [XW-1:0] tail_x_reg, tail_x_next;
    logic [RW-1:0] tail_row_reg, tail_row_next;
    logic [7:0]    cur_reg [bsd_pkg::NCH];
    logic [7:0]    hwin_reg [4][bsd_pkg::NCH];

    logic [7:0]    cur [bsd_pkg::NCH];
    logic [bsd_pkg::HS_W-1:0] hs [bsd_pkg::NCH];
    logic          cur_load, win_load, win_shift;
    logic          accept;

    // Issued operation.
    logic                 op_valid;
    bsd_pkg::op_meta_t    op_meta;
    logic [XW-1:0]        op_x;
    logic                 op_write;
    logic [1:0]           op_wslot;

    // Pipeline occupancy.
    logic              s1_valid_reg, s2_valid_reg, m_valid_reg;
    bsd_pkg::op_meta_t s1_meta_reg, s2_meta_reg;
    logic [LW-1:0]     s1_hs_reg;
    logic              out_free, s2_move, s2_free, s1_move, s1_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s2_move  = s2_valid_reg && (out_free || !s2_meta_reg.emit);
    assign s2_free  = !s2_valid_reg || s2_move;
    assign s1_move  = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s1_move;

    logic col_last, row_last, fl_le;
    logic [1:0] fl_hb;

    always_comb begin
        col_last = ({1'b0, WW'(col_reg)} >= {1'b0, eff_w - WW'(1)});
        row_last = (HW'(row_reg) >= eff_h - HW'(1));
        fl_le    = (WW'(fl_x_reg) == eff_w - WW'(1));
        fl_hb    = eff_h[1:0] - 2'd2 + {1'b0, fl_half_reg};
    end

    // Horizontal sums from the window and the current pixel.
    always_comb begin
        for (int ch = 0; ch < bsd_pkg::NCH; ch++) begin
            if (state_reg == bsd_pkg::SEQ_IDLE) begin
                cur[ch] = (ch == 0) ? s_in_ch0 :
                          !cfg_three_reg ? 8'd0 :
                          (ch == 1) ? s_in_ch1 : s_in_ch2;
            end else begin
                cur[ch] = cur_reg[ch];
            end
            hs[ch] = binom8(hwin_reg[0][ch], hwin_reg[1][ch], hwin_reg[2][ch],
                            hwin_reg[3][ch], cur[ch]);
        end
    end

    // A pixel-driven column operation reads the four rows above its row sum.
    function automatic bsd_pkg::op_meta_t pixel_meta(input logic [RW-1:0] r);
        bsd_pkg::op_meta_t m;
        logic [1:0] rb;
        m = '0;
        rb = r[1:0];
        m.emit    = (32'(r) >= 2);
        m.use_hs  = 1'b1;
        m.slot[0] = (32'(r) >= 4) ? rb : 2'd0;
        m.slot[1] = (32'(r) >= 3) ? rb + 2'd1 : 2'd0;
        m.slot[2] = rb + 2'd2;
        m.slot[3] = rb + 2'd3;
        m.slot[4] = rb;
        return m;
    endfunction

    always_comb begin
        state_next    = state_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        fl_x_next     = fl_x_reg;
        fl_half_next  = fl_half_reg;
        fl_pend_next  = fl_pend_reg;
        tail_x_next   = tail_x_reg;
        tail_row_next = tail_row_reg;
        cur_load      = 1'b0;
        win_load      = 1'b0;
        win_shift     = 1'b0;
        s_ready       = 1'b0;
        op_valid      = 1'b0;
        op_meta       = '0;
        op_x          = col_reg - XW'(2);
        op_write      = 1'b0;
        op_wslot      = row_reg[1:0];
        accept        = 1'b0;
        case (state_reg)
            bsd_pkg::SEQ_IDLE: begin
                s_ready = s1_free;
                accept  = s_valid && s1_free;
                if (accept && !s_kind) begin
                    cur_load      = 1'b1;
                    tail_x_next   = col_reg - XW'(1);
                    tail_row_next = row_reg;
                    if (col_reg == '0 && row_reg == '0) begin
                        op_valid          = 1'b1;
                        op_meta.clear_err = 1'b1;
                        fl_pend_next      = 1'b0;
                    end
                    if (col_reg == '0) begin
                        win_load = 1'b1;
                    end else begin
                        win_shift = 1'b1;
                        if (32'(col_reg) >= 2) begin
                            op_valid     = 1'b1;
                            op_meta      = pixel_meta(row_reg);
                            op_meta.last = !col_last;
                            op_write     = 1'b1;
                        end
                        if (col_last) begin
                            state_next = bsd_pkg::SEQ_TAIL1;
                        end
                    end
                    if (col_last) begin
                        col_next = '0;
                        if (row_last) begin
                            row_next     = '0;
                            fl_pend_next = 1'b1;
                            fl_x_next    = '0;
                            fl_half_next = 1'b0;
                        end else begin
                            row_next = row_reg + RW'(1);
                        end
                    end else begin
                        col_next = col_reg + XW'(1);
                    end
                end else if (accept && fl_pend_reg) begin
                    op_valid          = 1'b1;
                    op_x              = fl_x_reg;
                    op_meta.emit      = 1'b1;
                    op_meta.line_end  = fl_le;
                    op_meta.frame_end = fl_le && fl_half_reg;
                    op_meta.last      = 1'b1;
                    op_meta.slot[0]   = fl_hb - 2'd2;
                    op_meta.slot[1]   = fl_hb - 2'd1;
                    op_meta.slot[2]   = fl_hb;
                    op_meta.slot[3]   = fl_half_reg ? fl_hb : fl_hb + 2'd1;
                    op_meta.slot[4]   = fl_half_reg ? fl_hb : fl_hb + 2'd1;
                    if (fl_le) begin
                        fl_x_next = '0;
                        if (fl_half_reg) begin
                            fl_pend_next = 1'b0;
                        end else begin
                            fl_half_next = 1'b1;
                        end
                    end else begin
                        fl_x_next = fl_x_reg + XW'(1);
                    end
                end
            end
            bsd_pkg::SEQ_TAIL1: begin
                if (s1_free) begin
                    op_valid   = 1'b1;
                    op_meta    = pixel_meta(tail_row_reg);
                    op_x       = tail_x_reg;
                    op_write   = 1'b1;
                    op_wslot   = tail_row_reg[1:0];
                    win_shift  = 1'b1;
                    state_next = bsd_pkg::SEQ_TAIL2;
                end
            end
            bsd_pkg::SEQ_TAIL2: begin
                if (s1_free) begin
                    op_valid         = 1'b1;
                    op_meta          = pixel_meta(tail_row_reg);
                    op_meta.line_end = 1'b1;
                    op_meta.last     = 1'b1;
                    op_x             = tail_x_reg + XW'(1);
                    op_write         = 1'b1;
                    op_wslot         = tail_row_reg[1:0];
                    win_shift        = 1'b1;
                    state_next       = bsd_pkg::SEQ_IDLE;
                end
            end
            default: begin
                state_next = bsd_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bsd_pkg::SEQ_IDLE;
            col_reg     <= '0;
            row_reg     <= '0;
            fl_x_reg    <= '0;
            fl_half_reg <= 1'b0;
            fl_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            fl_x_reg    <= fl_x_next;
            fl_half_reg <= fl_half_next;
            fl_pend_reg <= fl_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        tail_x_reg   <= tail_x_next;
        tail_row_reg <= tail_row_next;
        for (int ch = 0; ch < bsd_pkg::NCH; ch++) begin
            if (cur_load) begin
                cur_reg[ch] <= cur[ch];
            end
            if (win_load) begin
                for (int k = 0; k < 4; k++) begin
                    hwin_reg[k][ch] <= cur[ch];
                end
            end else if (win_shift) begin
                hwin_reg[0][ch] <= hwin_reg[1][ch];
                hwin_reg[1][ch] <= hwin_reg[2][ch];
                hwin_reg[2][ch] <= hwin_reg[3][ch];
                hwin_reg[3][ch] <= cur[ch];
            end
        end
    end

    // Four line stores, one per row modulo four, all read at the same column.
    logic [LW-1:0] op_hs_packed;
    logic [LW-1:0] rd_data [4];

    always_comb begin
        for (int ch = 0; ch < bsd_pkg::NCH; ch++) begin
            op_hs_packed[ch*bsd_pkg::HS_W +: bsd_pkg::HS_W] = hs[ch];
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_line
        bsd_ram #(
            .WIDTH (LW),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .aclk  (aclk),
            .we    (op_valid && op_write && (op_wslot == 2'(g))),
            .waddr (op_x),
            .wdata (op_hs_packed),
            .re    (op_valid),
            .raddr (op_x),
            .rdata (rd_data[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s1_free) begin
                s1_valid_reg <= op_valid;
            end
            if (s2_free) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s2_move && s2_meta_reg.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_free && op_valid) begin
            s1_meta_reg <= op_meta;
            s1_hs_reg   <= op_hs_packed;
        end
        if (s1_move) begin
            s2_meta_reg <= s1_meta_reg;
        end
        if (s2_move && s2_meta_reg.emit) begin
            m_line_end    <= s2_meta_reg.line_end;
            m_frame_end   <= s2_meta_reg.frame_end;
            m_last_of_run <= s2_meta_reg.last;
        end
    end

    // One lane per channel; the merge below gathers their results into one transaction.
    logic [7:0] lane_res [bsd_pkg::NCH];

    for (genvar c = 0; c < bsd_pkg::NCH; c++) begin : g_lane
        bsd_pkg::lane_ctrl_t ctrl;
        logic [bsd_pkg::HS_W-1:0] v [5];

        always_comb begin
            for (int k = 0; k < 4; k++) begin
                v[k] = rd_data[s1_meta_reg.slot[k]][c*bsd_pkg::HS_W +: bsd_pkg::HS_W];
            end
            v[4] = s1_meta_reg.use_hs ? s1_hs_reg[c*bsd_pkg::HS_W +: bsd_pkg::HS_W] :
                   rd_data[s1_meta_reg.slot[4]][c*bsd_pkg::HS_W +: bsd_pkg::HS_W];
            ctrl.load_sum  = s1_move;
            ctrl.load_out  = s2_move && s2_meta_reg.emit;
            ctrl.clear_err = s2_move && s2_meta_reg.clear_err;
            ctrl.enable    = (c == 0) || cfg_three_reg;
            ctrl.dither    = cfg_dither_reg;
        end

        bsd_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .v0      (v[0]),
            .v1      (v[1]),
            .v2      (v[2]),
            .v3      (v[3]),
            .v4      (v[4]),
            .res     (lane_res[c])
        );
    end

    assign m_valid   = m_valid_reg;
    assign m_out_ch0 = lane_res[0];
    assign m_out_ch1 = lane_res[1];
    assign m_out_ch2 = lane_res[2];

endmodule

`default_nettype wire

@@ hw/rtl/bsd_checker.sv @@
`default_nettype none

module bsd_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_out_ch0,
    input wire logic       m_line_end,
    input wire logic       m_frame_end,
    input wire logic       m_last_of_run
);

    // A result that is not taken stays offered, with channel 0 unchanged.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_ch0))
        else $error("result transaction changed while stalled");

    // The last pixel of a frame is also the last of its line.
    a_frame_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> m_line_end)
        else $error("frame end without line end");

    // A line end is always the final result of the input transaction that caused it.
    a_line_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_line_end |-> m_last_of_run)
        else $error("line end not marked last of run");

    // Reset empties the output.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered after reset");

endmodule

bind binomial_smooth_5x5_dither bsd_checker u_bsd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_ch0     (m_out_ch0),
    .m_line_end    (m_line_end),
    .m_frame_end   (m_frame_end),
    .m_last_of_run (m_last_of_run)
);

`default_nettype wire

@@ tb/binomial_smooth_5x5_dither_tb.sv @@
`timescale 1ns / 100ps

module binomial_smooth_5x5_dither_tb;

    localparam int MAXW = 2048;
    localparam int MAXH = 4096;
    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD = 400;

    typedef struct {
        logic       kind;
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
    } pixel_txn_t;

    typedef struct {
        logic [7:0] o0;
        logic [7:0] o1;
        logic [7:0] o2;
        logic       le;
        logic       fe;
        logic       lr;
    } smooth_out_t;

    logic aclk;
    logic aresetn;
    logic cfg_we;
    logic [bsd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bsd_pkg::CFG_DATA_W-1:0] cfg_data;
    logic s_valid;
    logic s_ready;
    logic s_kind;
    logic [7:0] s_in_ch0, s_in_ch1, s_in_ch2;
    logic m_valid;
    logic m_ready;
    logic [7:0] m_out_ch0, m_out_ch1, m_out_ch2;
    logic m_line_end, m_frame_end, m_last_of_run;

    binomial_smooth_5x5_dither dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_in_ch0(s_in_ch0), .s_in_ch1(s_in_ch1), .s_in_ch2(s_in_ch2),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_ch0(m_out_ch0), .m_out_ch1(m_out_ch1), .m_out_ch2(m_out_ch2),
        .m_line_end(m_line_end), .m_frame_end(m_frame_end),
        .m_last_of_run(m_last_of_run)
    );

    // The clock runs at 100 MHz.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    pixel_txn_t  pixel_q[$];
    smooth_out_t smooth_q[$];
    int          mismatches;
    int          idle_cycles;
    bit          hold_req;
    bit          hold_done;

    // Shadow copy of the configuration, kept in step with every register write.
    logic [11:0] sh_width;
    logic [12:0] sh_height;
    logic        sh_three;
    logic        sh_dither;

    // Filter state as the predictor sees it.
    logic [7:0]  win[4][3];
    logic [15:0] row_sums[4*MAXW][3];
    logic [7:0]  err_carry[3];
    int          col_cnt;
    int          row_cnt;
    int          flush_cnt;
    bit          flush_pend;
    int          vsum[5][3];
    int          n_new;

    function automatic int taps5(int a, int b, int c, int d, int e);
        return a + e + 4 * (b + d) + 6 * c;
    endfunction

    function automatic int line_addr(int row, int x);
        return (row & 3) * MAXW + ((x >= MAXW) ? MAXW - 1 : x);
    endfunction

    function automatic int eff_w();
        return (sh_width < 2) ? 2 : ((sh_width > MAXW) ? MAXW : int'(sh_width));
    endfunction

    function automatic int eff_h();
        return (sh_height < 4) ? 4 : ((sh_height > MAXH) ? MAXH : int'(sh_height));
    endfunction

    // Vertical filter over vsum, then rounding or error diffusion into 8 bits.
    task automatic push_pixel(bit le, bit fe);
        smooth_out_t r;
        logic [15:0] s;
        logic [7:0]  o[3];
        for (int ch = 0; ch < 3; ch++) begin
            s = 16'(taps5(vsum[0][ch], vsum[1][ch], vsum[2][ch], vsum[3][ch], vsum[4][ch]));
            o[ch] = 8'd0;
            if (ch == 0 || sh_three) begin
                if (sh_dither) begin
                    s = s + 16'(err_carry[ch]);
                    err_carry[ch] = s[7:0];
                end else begin
                    s = s + 16'd128;
                end
                o[ch] = s[15:8];
            end
        end
        r.o0 = o[0];
        r.o1 = o[1];
        r.o2 = o[2];
        r.le = le;
        r.fe = fe;
        r.lr = 1'b0;
        smooth_q.push_back(r);
        n_new++;
    endtask

    // Horizontal sum for column x; emits the row two above once enough rows exist.
    task automatic column_sum(int x, logic [7:0] cur[3], bit le);
        int hs[3];
        int y;
        int rows[4];
        for (int ch = 0; ch < 3; ch++)
            hs[ch] = taps5(win[0][ch], win[1][ch], win[2][ch], win[3][ch], cur[ch]);
        if (row_cnt >= 2) begin
            y = row_cnt - 2;
            rows[0] = (y >= 2) ? y - 2 : 0;
            rows[1] = (y >= 1) ? y - 1 : 0;
            rows[2] = y;
            rows[3] = y + 1;
            for (int k = 0; k < 4; k++)
                for (int ch = 0; ch < 3; ch++)
                    vsum[k][ch] = row_sums[line_addr(rows[k], x)][ch];
            for (int ch = 0; ch < 3; ch++)
                vsum[4][ch] = hs[ch];
            push_pixel(le, 1'b0);
        end
        for (int ch = 0; ch < 3; ch++)
            row_sums[line_addr(row_cnt, x)][ch] = 16'(hs[ch]);
    endtask

    task automatic slide_window(logic [7:0] cur[3]);
        for (int k = 0; k < 3; k++)
            win[k] = win[k + 1];
        win[3] = cur;
    endtask

    // Advances the predicted filter state by one accepted input transaction.
    task automatic smooth_step(pixel_txn_t t);
        int w;
        int h;
        int y;
        int x;
        int rows[5];
        bit last;
        logic [7:0] cur[3];
        w = eff_w();
        h = eff_h();
        n_new = 0;
        if (t.kind == 1'b0) begin
            cur[0] = t.c0;
            cur[1] = sh_three ? t.c1 : 8'd0;
            cur[2] = sh_three ? t.c2 : 8'd0;
            last = (col_cnt >= w - 1);
            if (col_cnt == 0 && row_cnt == 0) begin
                err_carry = '{3{8'd0}};
                flush_pend = 1'b0;
            end
            if (col_cnt == 0) begin
                for (int k = 0; k < 4; k++)
                    win[k] = cur;
            end else begin
                if (col_cnt >= 2)
                    column_sum(col_cnt - 2, cur, 1'b0);
                slide_window(cur);
                if (last) begin
                    column_sum(col_cnt - 1, cur, 1'b0);
                    slide_window(cur);
                    column_sum(col_cnt, cur, 1'b1);
                end
            end
            if (last) begin
                col_cnt = 0;
                if (row_cnt >= h - 1) begin
                    row_cnt = 0;
                    flush_pend = 1'b1;
                    flush_cnt = 0;
                end else begin
                    row_cnt++;
                end
            end else begin
                col_cnt++;
            end
        end else if (flush_pend) begin
            if (flush_cnt >= 2 * w) begin
                flush_pend = 1'b0;
            end else begin
                y = h - 2 + flush_cnt / w;
                x = flush_cnt % w;
                rows[0] = y - 2;
                rows[1] = y - 1;
                rows[2] = y;
                rows[3] = (y + 1 > h - 1) ? h - 1 : y + 1;
                rows[4] = (y + 2 > h - 1) ? h - 1 : y + 2;
                for (int k = 0; k < 5; k++)
                    for (int ch = 0; ch < 3; ch++)
                        vsum[k][ch] = row_sums[line_addr(rows[k], x)][ch];
                push_pixel(x == w - 1, x == w - 1 && y == h - 1);
                flush_cnt = flush_cnt + 1;
                if (flush_cnt >= 2 * w)
                    flush_pend = 1'b0;
                flush_cnt = flush_cnt & 12'hFFF;
            end
        end
        if (n_new > 0)
            smooth_q[$].lr = 1'b1;
    endtask

    // Driver: pops pending transactions and offers them in bursts with random gaps.
    int burst_left;
    int gap_left;

    always @(posedge aclk) begin
        pixel_txn_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready)
                smooth_step('{s_kind, s_in_ch0, s_in_ch1, s_in_ch2});
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    nxt = pixel_q.pop_front();
                    s_kind   <= nxt.kind;
                    s_in_ch0 <= nxt.c0;
                    s_in_ch1 <= nxt.c1;
                    s_in_ch2 <= nxt.c2;
                    s_valid  <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: cycles through randomly chosen stall patterns; one long hold on request.
    int hold_left;
    int pat_cnt;
    int pat_mode;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left = 0;
            pat_cnt = 0;
            pat_mode = 0;
            hold_done = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            m_ready <= 1'b0;
        end else begin
            pat_cnt++;
            if (pat_cnt % 64 == 0)
                pat_mode = $urandom_range(0, 2);
            case (pat_mode)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= $urandom_range(0, 1);
                end
                default: begin
                    m_ready <= (pat_cnt % 4 == 0);
                end
            endcase
        end
    end

    // Monitor: every result transaction is checked against the oldest prediction.
    always @(posedge aclk) begin
        smooth_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (smooth_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transaction: ch %0d %0d %0d le %0b fe %0b lr %0b",
                             m_out_ch0, m_out_ch1, m_out_ch2,
                             m_line_end, m_frame_end, m_last_of_run);
            end else begin
                want = smooth_q.pop_front();
                if (m_out_ch0 !== want.o0 || m_out_ch1 !== want.o1 ||
                    m_out_ch2 !== want.o2 || m_line_end !== want.le ||
                    m_frame_end !== want.fe || m_last_of_run !== want.lr) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch: expected ch %0d %0d %0d le %0b fe %0b lr %0b,",
                                  " got ch %0d %0d %0d le %0b fe %0b lr %0b"},
                                 want.o0, want.o1, want.o2, want.le, want.fe, want.lr,
                                 m_out_ch0, m_out_ch1, m_out_ch2,
                                 m_line_end, m_frame_end, m_last_of_run);
                end
            end
        end
    end

    // Watchdog: counts cycles with outstanding work in which no transaction moves.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) ||
            (pixel_q.size() == 0 && !s_valid && smooth_q.size() == 0)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [bsd_pkg::CFG_IDX_W-1:0] idx, int val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= bsd_pkg::CFG_DATA_W'(val);
        case (idx)
            bsd_pkg::CFG_IMAGE_WIDTH:    sh_width = 12'(val);
            bsd_pkg::CFG_IMAGE_HEIGHT:   sh_height = 13'(val);
            bsd_pkg::CFG_THREE_CHANNELS: sh_three = val[0];
            default:                     sh_dither = val[0];
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_mode(int w, int h, int three, int dith);
        write_reg(bsd_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(bsd_pkg::CFG_IMAGE_HEIGHT, h);
        write_reg(bsd_pkg::CFG_THREE_CHANNELS, three);
        write_reg(bsd_pkg::CFG_DITHER_ENABLE, dith);
    endtask

    // Samples mix the extremes with random values so every bit toggles.
    function automatic logic [7:0] sample();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Queues one frame of pixels, optional stray flushes inside it, then the flush tail.
    task automatic queue_frame(int n_flush, bit stray);
        int w;
        int h;
        w = eff_w();
        h = eff_h();
        for (int i = 0; i < w * h; i++) begin
            pixel_q.push_back('{1'b0, sample(), sample(), sample()});
            if (stray && i > 0 && $urandom_range(0, 9) == 0)
                pixel_q.push_back('{1'b1, sample(), sample(), sample()});
        end
        for (int i = 0; i < n_flush; i++)
            pixel_q.push_back('{1'b1, sample(), sample(), sample()});
    endtask

    // The block may still be at work after the last result, so a short pause follows.
    task automatic drain();
        while (pixel_q.size() > 0 || s_valid || smooth_q.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    initial begin
        int w;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_kind    <= 1'b0;
        s_in_ch0  <= 8'd0;
        s_in_ch1  <= 8'd0;
        s_in_ch2  <= 8'd0;
        m_ready   <= 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        hold_req = 1'b0;
        sh_width = 12'd640;
        sh_height = 13'd480;
        sh_three = 1'b1;
        sh_dither = 1'b0;
        win = '{default: '{default: 8'd0}};
        err_carry = '{3{8'd0}};
        col_cnt = 0;
        row_cnt = 0;
        flush_cnt = 0;
        flush_pend = 1'b0;
        foreach (row_sums[i, j])
            row_sums[i][j] = 16'd0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: a stray flush with nothing pending, then the smallest frame
        // with full-scale samples, rounding and three channels.
        set_mode(2, 4, 1, 0);
        pixel_q.push_back('{1'b1, 8'd255, 8'd255, 8'd255});
        for (int i = 0; i < 8; i++)
            pixel_q.push_back('{1'b0, (i % 3 == 0) ? 8'd255 : 8'd0,
                                (i % 2 == 0) ? 8'd255 : 8'd0, 8'd255 - 8'(i * 37)});
        for (int i = 0; i < 5; i++)
            pixel_q.push_back('{1'b1, 8'd0, 8'd0, 8'd0});
        drain();

        // Directed: single channel with dither; width and height below their
        // minimums get clamped up.
        set_mode(1, 0, 0, 1);
        for (int i = 0; i < 8; i++)
            pixel_q.push_back('{1'b0, 8'd255, 8'd255, 8'd255});
        for (int i = 0; i < 4; i++)
            pixel_q.push_back('{1'b1, 8'd0, 8'd0, 8'd0});
        drain();

        // Random frames. One starts before the previous flush is done, which drops
        // the rest of that flush. The long receiver hold lands in the second frame.
        for (int f = 0; f < 4; f++) begin
            w = $urandom_range(2, 6);
            set_mode(w, $urandom_range(4, 5), $urandom_range(0, 1), $urandom_range(0, 1));
            if (f == 1)
                hold_req = 1'b1;
            queue_frame((f == 2) ? w : 2 * w + $urandom_range(0, 2), 1'b1);
            if (f == 2)
                queue_frame(2 * w, 1'b0);
            drain();
        end

        repeat (30) @(posedge aclk);
        if (mismatches == 0 && smooth_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ binomial_smooth_5x5_dither.f @@
hw/rtl/bsd_pkg.sv
hw/rtl/bsd_ram.sv
hw/rtl/bsd_lane.sv
hw/rtl/binomial_smooth_5x5_dither.sv
hw/rtl/bsd_checker.sv
tb/binomial_smooth_5x5_dither_tb.sv
